### rtl/core/bced_pkg.sv
package bced_pkg;

    localparam int MAX_LINE_DEF = 256;

    localparam int THRESH_W = 8;
    localparam int WIDTH_W  = 9;
    localparam int CFG_W    = 9;
    localparam int PIX_W    = 8;

    localparam logic [THRESH_W-1:0] THRESHOLD_RST  = 8'd127;
    localparam logic [WIDTH_W-1:0]  LINE_WIDTH_RST = 9'd256;

    localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
    localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

    // configuration register indexes
    localparam logic REG_THRESHOLD  = 1'b0;
    localparam logic REG_LINE_WIDTH = 1'b1;

    // input beat kinds
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef struct packed {
        logic                action;
        logic [PIX_W-1:0]    gray_in;
    } bced_in_t;

    typedef struct packed {
        logic [PIX_W-1:0]    edge_pixel;
        logic                frame_done;
    } bced_out_t;

    // control bits that travel with a beat down the cell chain
    typedef struct packed {
        logic wr;        // write the incoming-row bit at the beat's column
        logic emit;      // beat yields a result
        logic interior;  // cross test instead of border pass-through
        logic bank;      // bank select at acceptance
        logic down;      // thresholded pixel
        logic done;      // final pixel of the frame
    } bced_tok_t;

    // neighborhood bits gathered on the way through the chain
    typedef struct packed {
        logic left;
        logic center;
        logic right;
        logic up;
    } bced_nbr_t;

endpackage

### rtl/core/bced_cell.sv
module bced_cell #(
    parameter int MAX_LINE = bced_pkg::MAX_LINE_DEF,
    parameter int INDEX    = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv_i,
    input  logic                         tok_valid_i,
    input  bced_pkg::bced_tok_t          tok_i,
    input  logic [$clog2(MAX_LINE)-1:0]  addr_i,
    input  bced_pkg::bced_nbr_t          nbr_i,
    output logic                         tok_valid_o,
    output bced_pkg::bced_tok_t          tok_o,
    output logic [$clog2(MAX_LINE)-1:0]  addr_o,
    output bced_pkg::bced_nbr_t          nbr_o
);

    localparam int AW = $clog2(MAX_LINE);
    localparam bit HAS_NEXT = (INDEX + 1 < MAX_LINE);
    localparam bit HAS_PREV = (INDEX > 0);

    logic                a_reg;
    logic                b_reg;
    logic                tok_valid_reg;
    bced_pkg::bced_tok_t tok_reg;
    logic [AW-1:0]       addr_reg;
    bced_pkg::bced_nbr_t nbr_reg;
    bced_pkg::bced_nbr_t nbr_next;

    logic hit;
    logic hit_as_left;
    logic hit_as_right;
    logic mid_bit;
    logic inc_bit;

    always_comb begin
        hit          = tok_valid_i && (addr_i == AW'(INDEX));
        hit_as_left  = HAS_NEXT && tok_valid_i && (addr_i == AW'(INDEX + 1));
        hit_as_right = HAS_PREV && tok_valid_i && (addr_i == AW'(INDEX - 1));
        mid_bit      = tok_i.bank ? a_reg : b_reg;
        inc_bit      = tok_i.bank ? b_reg : a_reg;
        nbr_next     = nbr_i;
        if (hit) begin
            nbr_next.center = mid_bit;
            nbr_next.up     = inc_bit;
        end
        if (hit_as_left) begin
            nbr_next.left = mid_bit;
        end
        if (hit_as_right) begin
            nbr_next.right = mid_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_valid_reg <= 1'b0;
        end else if (adv_i) begin
            tok_valid_reg <= tok_valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_i) begin
            tok_reg  <= tok_i;
            addr_reg <= addr_i;
            nbr_reg  <= nbr_next;
            if (hit && tok_i.wr) begin
                if (tok_i.bank) begin
                    b_reg <= tok_i.down;
                end else begin
                    a_reg <= tok_i.down;
                end
            end
        end
    end

    assign tok_valid_o = tok_valid_reg;
    assign tok_o       = tok_reg;
    assign addr_o      = addr_reg;
    assign nbr_o       = nbr_reg;

endmodule

### rtl/core/bced_ctrl.sv
module bced_ctrl #(
    parameter int MAX_LINE = bced_pkg::MAX_LINE_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [bced_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                         accept_i,
    input  bced_pkg::bced_in_t           in_i,
    output logic                         tok_valid_o,
    output bced_pkg::bced_tok_t          tok_o,
    output logic [$clog2(MAX_LINE)-1:0]  addr_o
);

    localparam int AW    = $clog2(MAX_LINE);
    localparam int CMP_W = (AW >= bced_pkg::WIDTH_W) ? AW + 1 : bced_pkg::WIDTH_W;
    localparam logic [1:0] ROWS_FULL = 2'd2;

    logic [bced_pkg::THRESH_W-1:0] threshold_reg;
    logic [bced_pkg::WIDTH_W-1:0]  line_width_reg;

    logic          bank_select_reg, bank_select_next;
    logic [AW-1:0] column_count_reg, column_count_next;
    logic [1:0]    rows_seen_reg, rows_seen_next;
    logic [AW-1:0] flush_count_reg, flush_count_next;

    logic [CMP_W-1:0] lw_ext;
    logic [CMP_W-1:0] wm1_wide;
    logic [AW-1:0]    wm1;
    logic             last_col;
    logic             last_flush;
    logic             down;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= bced_pkg::THRESHOLD_RST;
            line_width_reg <= bced_pkg::LINE_WIDTH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bced_pkg::REG_THRESHOLD:  threshold_reg  <= cfg_wdata[bced_pkg::THRESH_W-1:0];
                bced_pkg::REG_LINE_WIDTH: line_width_reg <= cfg_wdata[bced_pkg::WIDTH_W-1:0];
            endcase
        end
    end

    // clamp the width to 3..MAX_LINE, keep width minus one
    always_comb begin
        lw_ext = CMP_W'(line_width_reg);
        if (lw_ext < CMP_W'(3)) begin
            wm1_wide = CMP_W'(2);
        end else if (lw_ext > CMP_W'(MAX_LINE)) begin
            wm1_wide = CMP_W'(MAX_LINE - 1);
        end else begin
            wm1_wide = lw_ext - CMP_W'(1);
        end
        wm1        = wm1_wide[AW-1:0];
        last_col   = column_count_reg >= wm1;
        last_flush = flush_count_reg >= wm1;
        down       = in_i.gray_in > threshold_reg;
    end

    always_comb begin
        bank_select_next  = bank_select_reg;
        column_count_next = column_count_reg;
        rows_seen_next    = rows_seen_reg;
        flush_count_next  = flush_count_reg;
        tok_valid_o       = 1'b0;
        tok_o             = '0;
        addr_o            = column_count_reg;
        if (accept_i) begin
            if (in_i.action == bced_pkg::ACT_FLUSH) begin
                // drop a flush before any full row or in the middle of a row
                if (rows_seen_reg != 2'd0 && column_count_reg == '0) begin
                    tok_valid_o = 1'b1;
                    tok_o.emit  = 1'b1;
                    tok_o.bank  = bank_select_reg;
                    tok_o.done  = last_flush;
                    addr_o      = flush_count_reg;
                    if (last_flush) begin
                        bank_select_next  = 1'b0;
                        column_count_next = '0;
                        rows_seen_next    = 2'd0;
                        flush_count_next  = '0;
                    end else begin
                        flush_count_next = flush_count_reg + AW'(1);
                    end
                end
            end else if (flush_count_reg == '0) begin
                tok_valid_o    = 1'b1;
                tok_o.wr       = 1'b1;
                tok_o.emit     = (rows_seen_reg != 2'd0);
                tok_o.interior = (rows_seen_reg == ROWS_FULL) &&
                                 (column_count_reg != '0) && !last_col;
                tok_o.bank     = bank_select_reg;
                tok_o.down     = down;
                addr_o         = column_count_reg;
                if (last_col) begin
                    column_count_next = '0;
                    bank_select_next  = !bank_select_reg;
                    if (rows_seen_reg != ROWS_FULL) begin
                        rows_seen_next = rows_seen_reg + 2'd1;
                    end
                end else begin
                    column_count_next = column_count_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_select_reg  <= 1'b0;
            column_count_reg <= '0;
            rows_seen_reg    <= 2'd0;
            flush_count_reg  <= '0;
        end else begin
            bank_select_reg  <= bank_select_next;
            column_count_reg <= column_count_next;
            rows_seen_reg    <= rows_seen_next;
            flush_count_reg  <= flush_count_next;
        end
    end

    a_rows_saturate: assert property (@(posedge aclk) disable iff (!aresetn)
        rows_seen_reg != 2'd3)
        else $error("rows_seen past saturation");

    a_flush_at_row_start: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_count_reg != '0 |-> (column_count_reg == '0 && rows_seen_reg != 2'd0))
        else $error("flush in progress outside a row boundary");

    a_frame_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (tok_valid_o && tok_o.done) |=>
            (rows_seen_reg == 2'd0 && bank_select_reg == 1'b0 && flush_count_reg == '0))
        else $error("frame end did not return the sequencer to its start");

    a_pixel_blocked_in_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept_i && in_i.action == bced_pkg::ACT_PIXEL && flush_count_reg != '0)
            |-> !tok_valid_o)
        else $error("pixel beat entered the chain during flush");

endmodule

### rtl/core/binary_cross_edge_detector.sv
// A beat passes MAX_LINE cells, each holding the two line-store bits of its column, then the
//   output register. Throughput: one beat per cycle, one column cell per cycle, while the
//   chain advances; it freezes while a result waits and the sink holds off.
// Reset (aresetn low, synchronous): threshold 127, line_width 256, sequencer at frame start,
//   chain and output empty; line-store bits stay as they are until written.
module binary_cross_edge_detector #(
    parameter int MAX_LINE = bced_pkg::MAX_LINE_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    // configuration write port
    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [bced_pkg::CFG_W-1:0]   cfg_wdata,

    // pixel / flush beats in
    input  logic                         s_valid,
    output logic                         s_ready,
    input  bced_pkg::bced_in_t           s_payload,

    // result beats out
    output logic                         m_valid,
    input  logic                         m_ready,
    output bced_pkg::bced_out_t          m_payload
);

    localparam int AW = $clog2(MAX_LINE);

    // Whole chain moves together; freeze it only while a result waits in the
    // output register and the sink holds off.
    logic adv;
    logic accept;

    logic                m_valid_reg;
    bced_pkg::bced_out_t m_payload_reg;

    logic                chain_valid [0:MAX_LINE];
    bced_pkg::bced_tok_t chain_tok   [0:MAX_LINE];
    logic [AW-1:0]       chain_addr  [0:MAX_LINE];
    bced_pkg::bced_nbr_t chain_nbr   [0:MAX_LINE];

    bced_pkg::bced_tok_t end_tok;
    bced_pkg::bced_nbr_t end_nbr;
    logic                same;
    bced_pkg::bced_out_t result;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && s_ready;

    // Sequencer: thresholds the pixel, tracks column, row count, bank and
    // flush position, and launches one beat into the chain (or drops it).
    bced_ctrl #(
        .MAX_LINE (MAX_LINE)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .accept_i    (accept),
        .in_i        (s_payload),
        .tok_valid_o (chain_valid[0]),
        .tok_o       (chain_tok[0]),
        .addr_o      (chain_addr[0])
    );

    assign chain_nbr[0] = '0;

    // Column cells: cell k owns column k of both line stores. A beat picks up
    // left, center, right and up as it passes columns j-1, j, j+1, and writes
    // its thresholded bit at column j. Beats never overtake, so every read
    // sees all writes of earlier beats.
    for (genvar k = 0; k < MAX_LINE; k++) begin : g_cell
        bced_cell #(
            .MAX_LINE (MAX_LINE),
            .INDEX    (k)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .adv_i       (adv),
            .tok_valid_i (chain_valid[k]),
            .tok_i       (chain_tok[k]),
            .addr_i      (chain_addr[k]),
            .nbr_i       (chain_nbr[k]),
            .tok_valid_o (chain_valid[k+1]),
            .tok_o       (chain_tok[k+1]),
            .addr_o      (chain_addr[k+1]),
            .nbr_o       (chain_nbr[k+1])
        );
    end

    // Result: border beats pass the center bit; interior beats go white when
    // all four cross neighbors agree.
    always_comb begin
        end_tok = chain_tok[MAX_LINE];
        end_nbr = chain_nbr[MAX_LINE];
        same    = (end_nbr.up == end_nbr.left) && (end_tok.down == end_nbr.right) &&
                  (end_nbr.up == end_tok.down) && (end_nbr.left == end_nbr.right);
        if (end_tok.interior) begin
            result.edge_pixel = same ? bced_pkg::PIX_WHITE : bced_pkg::PIX_BLACK;
        end else begin
            result.edge_pixel = end_nbr.center ? bced_pkg::PIX_WHITE : bced_pkg::PIX_BLACK;
        end
        result.frame_done = end_tok.done;
    end

    // Output register: load the chain's last beat when it carries a result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= chain_valid[MAX_LINE] && end_tok.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_payload_reg <= result;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule
